// ----- hw/rtl/rcgs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture group scanner package
// Shared limits, character codes, types and the capture test used by the
// scanner's mode tracker, group stack and top level.
// ----------------------------------------------------------------------------
package rcgs_pkg;

    localparam int MAX_PATTERN_LEN = 4096;
    localparam int MAX_NESTING     = 32;

    // Position counter must also hold MAX_PATTERN_LEN itself.
    localparam int POS_W   = $clog2(MAX_PATTERN_LEN + 1);
    localparam int START_W = $clog2(MAX_PATTERN_LEN);
    localparam int DEPTH_W = $clog2(MAX_NESTING + 1);
    localparam int IDX_W   = $clog2(MAX_NESTING);

    // Widths of the result fields.
    localparam int GROUP_START_W = 12;
    localparam int GROUP_STOP_W  = 13;

    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_Q          = 8'h51;
    localparam logic [7:0] CH_E          = 8'h45;
    localparam logic [7:0] CH_QUESTION   = 8'h3F;
    localparam logic [7:0] CH_P          = 8'h50;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;

    // Group open/close request from the mode tracker, meaningful only when
    // the byte is processed.
    typedef struct packed {
        logic push;
        logic pop;
    } stack_cmd_t;

    // What the group stack reports for the current byte.
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
        logic               nest_ovf;
    } group_info_t;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    // Lookahead holds the first byte after '(' in bits 7:0, then the second
    // and third; bytes never seen read as zero.
    function automatic logic is_capturing(input logic [23:0] la);
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
        first  = la[7:0];
        second = la[15:8];
        third  = la[23:16];
        if (first == CH_QUESTION)
        begin
            is_capturing = (second == CH_QUOTE)
                        || ((second == CH_LESS) && (is_letter(third) || (third == CH_UNDERSCORE)))
                        || ((second == CH_P) && (third == CH_LESS));
        end
        else
        begin
            is_capturing = (first != CH_STAR);
        end
    endfunction

endpackage

// ----- hw/rtl/rcgs_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern byte channel
// Valid/ready channel carrying one pattern byte and its final-byte flag.
// ----------------------------------------------------------------------------
interface rcgs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pattern_byte;
    logic       is_final;

    modport source (output valid, output pattern_byte, output is_final, input ready);
    modport sink (input valid, input pattern_byte, input is_final, output ready);
endinterface

// ----- hw/rtl/rcgs_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan result channel
// Valid/ready channel carrying one capture group report or end-of-pattern.
// ----------------------------------------------------------------------------
interface rcgs_out_if;
    logic        valid;
    logic        ready;
    logic        group_found;
    logic [11:0] group_start;
    logic [12:0] group_stop;
    logic        pattern_done;
    logic        overflowed;

    modport source (output valid, output group_found, output group_start,
                    output group_stop, output pattern_done, output overflowed,
                    input ready);
    modport sink (input valid, input group_found, input group_start,
                  input group_stop, input pattern_done, input overflowed,
                  output ready);
endinterface

// ----- hw/rtl/rcgs_mode_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanner mode tracker
// Keeps the escape, class and quoted-literal flags and turns unescaped
// parentheses in normal mode into group open and close requests.
// ----------------------------------------------------------------------------
module rcgs_mode_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                clear,
    input  logic [7:0]          pattern_byte,
    output rcgs_pkg::stack_cmd_t cmd
);
    import rcgs_pkg::*;

    logic escape_reg;
    logic class_reg;
    logic literal_reg;
    logic pending_reg;
    logic escape_next;
    logic class_next;
    logic literal_next;
    logic pending_next;

    // Escape wins over class, class over literal, literal over normal.
    always_comb
    begin
        escape_next  = escape_reg;
        class_next   = class_reg;
        literal_next = literal_reg;
        pending_next = pending_reg;
        cmd          = '0;
        if (escape_reg)
        begin
            escape_next = 1'b0;
            if (pattern_byte == CH_Q)
            begin
                literal_next = 1'b1;
            end
        end
        else if (class_reg)
        begin
            if (pattern_byte == CH_RBRACKET)
            begin
                class_next = 1'b0;
            end
            if (pattern_byte == CH_BACKSLASH)
            begin
                escape_next = 1'b1;
            end
        end
        else if (literal_reg)
        begin
            if (pending_reg && (pattern_byte == CH_E))
            begin
                literal_next = 1'b0;
                pending_next = 1'b0;
            end
            else
            begin
                pending_next = (pattern_byte == CH_BACKSLASH);
            end
        end
        else if (pattern_byte == CH_BACKSLASH)
        begin
            escape_next = 1'b1;
        end
        else if (pattern_byte == CH_LBRACKET)
        begin
            class_next = 1'b1;
        end
        else if (pattern_byte == CH_LPAREN)
        begin
            cmd.push = 1'b1;
        end
        else if (pattern_byte == CH_RPAREN)
        begin
            cmd.pop = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg  <= 1'b0;
            class_reg   <= 1'b0;
            literal_reg <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (clear)
        begin
            escape_reg  <= 1'b0;
            class_reg   <= 1'b0;
            literal_reg <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (step)
        begin
            escape_reg  <= escape_next;
            class_reg   <= class_next;
            literal_reg <= literal_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ----- hw/rtl/rcgs_group_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Open group stack
// Holds the start position and three lookahead bytes of each open group.
// Lookahead of a group is written once complete; younger groups take it
// from a short byte history instead.
// ----------------------------------------------------------------------------
module rcgs_group_stack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          clear,
    input  logic [7:0]                    pattern_byte,
    input  logic [rcgs_pkg::START_W-1:0]  cur_pos,
    input  rcgs_pkg::stack_cmd_t          cmd,
    output rcgs_pkg::group_info_t         info
);
    import rcgs_pkg::*;

    logic [START_W-1:0] start_mem [MAX_NESTING];
    logic [23:0]        la_mem [MAX_NESTING];

    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;

    // Groups opened one, two and three bytes ago, still open.
    logic [2:0]         push_vld_reg;
    logic [2:0]         push_vld_next;
    logic [IDX_W-1:0]   push_idx_reg [3];
    // Bytes processed one and two positions ago.
    logic [7:0]         hist_reg [2];

    logic               full;
    logic [IDX_W-1:0]   top_idx;
    logic               push_do;
    logic               pop_do;
    logic [23:0]        top_la;

    assign full    = (depth_reg == DEPTH_W'(MAX_NESTING));
    assign top_idx = IDX_W'(depth_reg - DEPTH_W'(1));
    assign push_do = step && cmd.push && !full;
    assign pop_do  = step && cmd.pop && (depth_reg != '0);

    always_comb
    begin
        if (push_vld_reg[0] && (push_idx_reg[0] == top_idx))
        begin
            top_la = {16'h0000, pattern_byte};
        end
        else if (push_vld_reg[1] && (push_idx_reg[1] == top_idx))
        begin
            top_la = {8'h00, pattern_byte, hist_reg[0]};
        end
        else if (push_vld_reg[2] && (push_idx_reg[2] == top_idx))
        begin
            top_la = {pattern_byte, hist_reg[0], hist_reg[1]};
        end
        else
        begin
            top_la = la_mem[top_idx];
        end
    end

    always_comb
    begin
        info.found    = pop_do && is_capturing(top_la);
        info.start    = start_mem[top_idx];
        info.nest_ovf = step && cmd.push && full;
    end

    always_comb
    begin
        depth_next = depth_reg;
        if (push_do)
        begin
            depth_next = depth_reg + DEPTH_W'(1);
        end
        else if (pop_do)
        begin
            depth_next = depth_reg - DEPTH_W'(1);
        end
        push_vld_next[0] = push_do;
        push_vld_next[1] = push_vld_reg[0] && !(pop_do && (push_idx_reg[0] == top_idx));
        push_vld_next[2] = push_vld_reg[1] && !(pop_do && (push_idx_reg[1] == top_idx));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg    <= '0;
            push_vld_reg <= '0;
        end
        else if (clear)
        begin
            depth_reg    <= '0;
            push_vld_reg <= '0;
        end
        else if (step)
        begin
            depth_reg    <= depth_next;
            push_vld_reg <= push_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            push_idx_reg[0] <= depth_reg[IDX_W-1:0];
            push_idx_reg[1] <= push_idx_reg[0];
            push_idx_reg[2] <= push_idx_reg[1];
            hist_reg[0]     <= pattern_byte;
            hist_reg[1]     <= hist_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_do)
        begin
            start_mem[depth_reg[IDX_W-1:0]] <= cur_pos;
        end
    end

    // The group opened three bytes ago has now seen all its lookahead.
    always_ff @(posedge clk)
    begin
        if (step && push_vld_reg[2])
        begin
            la_mem[push_idx_reg[2]] <= {pattern_byte, hist_reg[0], hist_reg[1]};
        end
    end

endmodule

// ----- hw/rtl/regex_capture_group_scanner_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Regex capture group scanner core
// Scans a regular-expression pattern byte by byte and reports the span of
// every capturing group as its closing parenthesis arrives.
// ----------------------------------------------------------------------------
// Usage:
// The pattern channel takes one pattern byte per request, with is_final set
// on the last byte of a pattern. The result channel gives one request for a
// byte that closes a capturing group, for the final byte, or for both at
// once; other bytes give no result.
// The result of a byte is registered at the edge that accepts it and is valid
// after that edge. One byte is accepted every cycle unless a result waits
// untaken in the single result register; mode flags, position and group
// stack all settle in the same cycle.
// When the receiver stalls, the pending result stays in the result register
// and the pattern channel still accepts a byte in a cycle where the result
// is taken; only with a result waiting and not taken is ready held low.
// Reset, and the final byte of every pattern, clear the modes, position,
// open groups and the overflow flag; open groups left at the end are
// dropped without a report. Stack contents need no clearing pass.
// ----------------------------------------------------------------------------
module regex_capture_group_scanner_core (
    input  logic      clk,
    input  logic      rst_n,
    rcgs_in_if.sink   pattern,
    rcgs_out_if.source result
);
    import rcgs_pkg::*;

    logic               accept;
    logic               processed;
    logic               step;
    logic               fin_accept;
    logic               emit;
    stack_cmd_t         cmd;
    group_info_t        info;

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               overflow_reg;
    logic               overflow_now;

    logic               out_valid_reg;
    logic               found_reg;
    logic [GROUP_START_W-1:0] start_reg;
    logic [GROUP_STOP_W-1:0]  stop_reg;
    logic               done_reg;
    logic               ovf_out_reg;

    // The result register frees up in the same cycle it is taken, so a new
    // byte can follow every cycle while results are taken.
    assign pattern.ready = !out_valid_reg || result.ready;
    assign accept        = pattern.valid && pattern.ready;
    // Bytes beyond the length limit change nothing but the overflow flag.
    assign processed     = (pos_reg < POS_W'(MAX_PATTERN_LEN));
    assign step          = accept && processed;
    assign fin_accept    = accept && pattern.is_final;

    rcgs_mode_ctrl u_mode_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .clear        (fin_accept),
        .pattern_byte (pattern.pattern_byte),
        .cmd          (cmd)
    );

    rcgs_group_stack u_group_stack (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .clear        (fin_accept),
        .pattern_byte (pattern.pattern_byte),
        .cur_pos      (pos_reg[START_W-1:0]),
        .cmd          (cmd),
        .info         (info)
    );

    // The overflow reported with a byte already includes that byte's effect.
    assign overflow_now = overflow_reg || (accept && !processed) || info.nest_ovf;
    assign emit         = accept && (info.found || pattern.is_final);

    always_comb
    begin
        pos_next = pos_reg;
        if (fin_accept)
        begin
            pos_next = '0;
        end
        else if (step)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (fin_accept)
            begin
                overflow_reg <= 1'b0;
            end
            else if (accept)
            begin
                overflow_reg <= overflow_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Span fields read as zero when no group closed on this byte.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_reg   <= info.found;
            start_reg   <= info.found ? GROUP_START_W'(info.start) : '0;
            stop_reg    <= info.found ? GROUP_STOP_W'(pos_reg + POS_W'(1)) : '0;
            done_reg    <= pattern.is_final;
            ovf_out_reg <= overflow_now;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.group_found  = found_reg;
    assign result.group_start  = start_reg;
    assign result.group_stop   = stop_reg;
    assign result.pattern_done = done_reg;
    assign result.overflowed   = ovf_out_reg;

`ifndef ASSERT_OFF
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.group_found) |->
            (result.group_stop > {1'b0, result.group_start}))
        else $error("group span does not end after its start");

    a_final_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
        fin_accept |=> (pos_reg == '0) && !overflow_reg)
        else $error("state not cleared after final byte");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pattern.ready |-> out_valid_reg)
        else $error("input stalled with an empty result register");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (overflow_reg && !fin_accept) |=> overflow_reg)
        else $error("overflow flag dropped before end of pattern");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_PATTERN_LEN))
        else $error("byte position beyond length limit");
`endif

endmodule

// ----- tb/sv/regex_capture_group_scanner_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture group scanner testbench
// Streams regular-expression patterns into the scanner core one byte per
// request and checks every group report and end-of-pattern result against
// a cycle-free scan of the same bytes, under random idling on both sides.
// ----------------------------------------------------------------------------
module regex_capture_group_scanner_core_tb;

    import rcgs_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int IDLE_PCT     = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_PRINTED  = 40;
    localparam int RANDOM_BYTES = 600;
    localparam int BURST_BYTES  = 300;

    // Letter bounds for the group name test.
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef logic [7:0] text_t[$];

    // One result request as the scanner should present it.
    typedef struct packed {
        logic                     found;
        logic [GROUP_START_W-1:0] start;
        logic [GROUP_STOP_W-1:0]  stop;
        logic                     done;
        logic                     ovf;
    } group_report_t;

    logic clk;
    logic rst_n;

    rcgs_in_if  pat_if ();
    rcgs_out_if res_if ();

    regex_capture_group_scanner_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pattern(pat_if),
        .result (res_if)
    );

    // Scan state mirrored from the pattern bytes that the core has accepted.
    logic                     sc_escape;
    logic                     sc_class;
    logic                     sc_literal;
    logic                     sc_lit_bs;
    int unsigned              sc_pos;
    int                       sc_depth;
    logic [GROUP_START_W-1:0] sc_start [MAX_NESTING];
    logic [25:0]              sc_look  [MAX_NESTING];
    logic                     sc_ovf;

    // Reports worked out from accepted bytes, oldest first.
    group_report_t group_reports[$];

    // Idling controls, changed by the test tasks.
    int   tx_idle_pct  = IDLE_PCT;
    int   rx_idle_pct  = IDLE_PCT;
    logic hold_request = 1'b0;

    int error_count     = 0;
    int bytes_offered   = 0;
    int bytes_taken     = 0;
    int patterns_sent   = 0;
    int results_checked = 0;
    int groups_reported = 0;
    int done_reported   = 0;
    int ovf_reported    = 0;
    int stall_cycles    = 0;
    int hold_count      = 0;
    int quiet_cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Scan model
    // ------------------------------------------------------------------------

    task automatic clear_scan_state();
        int i;
        sc_escape  = 1'b0;
        sc_class   = 1'b0;
        sc_literal = 1'b0;
        sc_lit_bs  = 1'b0;
        sc_pos     = 0;
        sc_depth   = 0;
        sc_ovf     = 1'b0;
        for (i = 0; i < MAX_NESTING; i++)
        begin
            sc_start[i] = '0;
            sc_look[i]  = '0;
        end
    endtask

    // The three bytes after '(' decide whether the group captures. Bytes
    // never seen before the ')' read as zero.
    function automatic logic opens_capture(input logic [23:0] la);
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic       name_char;
        c1 = la[7:0];
        c2 = la[15:8];
        c3 = la[23:16];
        name_char = ((c3 >= CH_UPPER_A) && (c3 <= CH_UPPER_Z))
                 || ((c3 >= CH_LOWER_A) && (c3 <= CH_LOWER_Z))
                 || (c3 == CH_UNDERSCORE);
        if (c1 == CH_QUESTION)
            return (c2 == CH_QUOTE) || ((c2 == CH_LESS) && name_char)
                || ((c2 == CH_P) && (c3 == CH_LESS));
        return c1 != CH_STAR;
    endfunction

    // Advances the scan by one accepted byte and queues the report it
    // causes, if any.
    task automatic scan_byte(input logic [7:0] b, input logic fin);
        group_report_t rep;
        int            i;
        int            top;
        logic [1:0]    seen;
        rep = '0;
        if (sc_pos >= MAX_PATTERN_LEN)
        begin
            // Past the length limit the byte is dropped, but the flag sticks.
            sc_ovf = 1'b1;
        end
        else
        begin
            // Every open group collects up to three bytes of lookahead,
            // including the byte that closes it.
            for (i = 0; i < sc_depth; i++)
            begin
                seen = sc_look[i][25:24];
                if (seen != 2'd3)
                begin
                    sc_look[i][8 * seen +: 8] = b;
                    sc_look[i][25:24]         = seen + 2'd1;
                end
            end

            // Escape outranks a class, which outranks a literal run.
            if (sc_escape)
            begin
                sc_escape = 1'b0;
                if (b == CH_Q)
                    sc_literal = 1'b1;
            end
            else if (sc_class)
            begin
                if (b == CH_RBRACKET)
                    sc_class = 1'b0;
                if (b == CH_BACKSLASH)
                    sc_escape = 1'b1;
            end
            else if (sc_literal)
            begin
                if (sc_lit_bs && (b == CH_E))
                begin
                    sc_literal = 1'b0;
                    sc_lit_bs  = 1'b0;
                end
                else
                    sc_lit_bs = (b == CH_BACKSLASH);
            end
            else if (b == CH_BACKSLASH)
                sc_escape = 1'b1;
            else if (b == CH_LBRACKET)
                sc_class = 1'b1;
            else if (b == CH_LPAREN)
            begin
                if (sc_depth >= MAX_NESTING)
                    sc_ovf = 1'b1;
                else
                begin
                    sc_start[sc_depth] = GROUP_START_W'(sc_pos);
                    sc_look[sc_depth]  = '0;
                    sc_depth++;
                end
            end
            else if ((b == CH_RPAREN) && (sc_depth > 0))
            begin
                top = sc_depth - 1;
                if (opens_capture(sc_look[top][23:0]))
                begin
                    rep.found = 1'b1;
                    rep.start = sc_start[top];
                    rep.stop  = GROUP_STOP_W'(sc_pos + 1);
                end
                sc_depth = top;
            end
            sc_pos++;
        end

        if (rep.found || fin)
        begin
            rep.done = fin;
            rep.ovf  = sc_ovf;
            group_reports.insert(group_reports.size(), rep);
        end
        if (fin)
            clear_scan_state();
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR at %0t, result %0d: %s is %0h, should be %0h",
                     $realtime, results_checked, what, got, want);
    endtask

    // Both channels are sampled at the rising edge, before any update made at
    // that edge, so the byte accepted at an edge is scanned before the result
    // taken at the same edge is compared.
    always @(posedge clk)
    begin : check_requests
        group_report_t want;
        if (rst_n === 1'b1)
        begin
            if ((pat_if.valid === 1'b1) && (pat_if.ready !== 1'b1))
                stall_cycles++;
            if ((pat_if.valid === 1'b1) && (pat_if.ready === 1'b1))
            begin
                bytes_taken++;
                scan_byte(pat_if.pattern_byte, pat_if.is_final);
            end
            if ((res_if.valid === 1'b1) && (res_if.ready === 1'b1))
            begin
                if (group_reports.size() == 0)
                    report_mismatch("result with no report waiting", 32'd0, 32'd0);
                else
                begin
                    want = group_reports.pop_front();
                    if (res_if.group_found !== want.found)
                        report_mismatch("group_found", 32'(res_if.group_found),
                                        32'(want.found));
                    if (res_if.group_start !== want.start)
                        report_mismatch("group_start", 32'(res_if.group_start),
                                        32'(want.start));
                    if (res_if.group_stop !== want.stop)
                        report_mismatch("group_stop", 32'(res_if.group_stop),
                                        32'(want.stop));
                    if (res_if.pattern_done !== want.done)
                        report_mismatch("pattern_done", 32'(res_if.pattern_done),
                                        32'(want.done));
                    if (res_if.overflowed !== want.ovf)
                        report_mismatch("overflowed", 32'(res_if.overflowed),
                                        32'(want.ovf));
                    if (want.found)
                        groups_reported++;
                    if (want.done)
                        done_reported++;
                    if (want.ovf)
                        ovf_reported++;
                end
                results_checked++;
            end
        end
    end

    // Ends the run when no request moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (((pat_if.valid === 1'b1) && (pat_if.ready === 1'b1))
                || ((res_if.valid === 1'b1) && (res_if.ready === 1'b1)))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog: no request moved for %0d cycles, %0d reports outstanding",
                         quiet_cycles, group_reports.size());
                $display("regex_capture_group_scanner_core: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver
    // ------------------------------------------------------------------------

    // Takes results with random stalls. When a hold-off is asked for, ready
    // stays low for a long fixed stretch so that the core's single result
    // register fills and the pattern channel backs up.
    initial
    begin
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                hold_count++;
            end
            else
                res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Pattern sender
    // ------------------------------------------------------------------------

    // Offers one byte and returns in the time step of the edge that accepted
    // it. Valid is left high so that the next byte can follow without a gap;
    // a gap, when drawn, lowers valid in this step and raises it later.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if ((tx_idle_pct > 0) && ($urandom_range(99) < tx_idle_pct))
        begin
            pat_if.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        pat_if.valid        <= 1'b1;
        pat_if.pattern_byte <= b;
        pat_if.is_final     <= fin;
        bytes_offered++;
        @(posedge clk);
        while (pat_if.ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic send_pattern(input text_t q);
        int i;
        patterns_sent++;
        for (i = 0; i < q.size(); i++)
            send_byte(q[i], i == q.size() - 1);
    endtask

    // Adds one byte at the end of a pattern under construction.
    task automatic append_byte(ref text_t q, input logic [7:0] b);
        q.insert(q.size(), b);
    endtask

    task automatic push_text(ref text_t q, input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            append_byte(q, s[i]);
    endtask

    task automatic send_text(input string s);
        text_t q;
        push_text(q, s);
        send_pattern(q);
    endtask

    function automatic logic [7:0] pick_byte(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    // Waits until every accepted byte has been scanned and every report has
    // come back, then lets a tail of idle cycles pass so that a stray result would show.
    task automatic drain_results();
        pat_if.valid <= 1'b0;
        while ((bytes_taken != bytes_offered) || (group_reports.size() != 0))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Builds a random pattern. Most are made of well-formed pieces (groups
    // with the various prefixes, escapes, bracket classes, quoted literal
    // runs) so that groups actually open and close; a few are raw noise.
    task automatic build_pattern(ref text_t q);
        int         open_groups;
        int         n;
        int         kind;
        int         m;
        logic [7:0] b;
        logic       with_quote;
        q.delete();
        open_groups = 0;
        if ($urandom_range(99) < 12)
        begin
            n = $urandom_range(20, 1);
            repeat (n) append_byte(q, 8'($urandom));
            return;
        end
        n = $urandom_range(12, 1);
        repeat (n)
        begin
            kind = $urandom_range(99);
            if (kind < 28)
            begin
                append_byte(q, CH_LPAREN);
                open_groups++;
                case ($urandom_range(8))
                    2: push_text(q, "?:");
                    3: push_text(q, "?'");
                    4:
                    begin
                        push_text(q, "?<");
                        // Name characters around the letter ranges.
                        if ($urandom_range(9) == 0)
                            b = CH_LOWER_A - 8'd1;
                        else if ($urandom_range(4) == 0)
                            b = 8'($urandom);
                        else
                            b = pick_byte("_@[{AZaz");
                        append_byte(q, b);
                    end
                    5: push_text(q, "?P<");
                    6: push_text(q, "?P=");
                    7: append_byte(q, CH_STAR);
                    8:
                    begin
                        append_byte(q, CH_QUESTION);
                        append_byte(q, 8'($urandom));
                    end
                    default: ;
                endcase
            end
            else if (kind < 50)
            begin
                append_byte(q, CH_RPAREN);
                if (open_groups > 0)
                    open_groups--;
            end
            else if (kind < 68)
                append_byte(q, CH_LOWER_A + 8'($urandom_range(25)));
            else if (kind < 76)
            begin
                b = 8'($urandom);
                if (b == CH_Q)
                    b = CH_LPAREN;
                append_byte(q, CH_BACKSLASH);
                append_byte(q, b);
            end
            else if (kind < 84)
            begin
                // A class; a quoted run opened inside it outlives the ']'.
                append_byte(q, CH_LBRACKET);
                m = $urandom_range(3);
                repeat (m) append_byte(q, pick_byte("()a^-"));
                if ($urandom_range(4) == 0)
                    push_text(q, "\\]");
                with_quote = ($urandom_range(9) == 0);
                if (with_quote)
                    push_text(q, "\\Q");
                append_byte(q, CH_RBRACKET);
                if (with_quote)
                    push_text(q, "\\E");
            end
            else if (kind < 92)
            begin
                push_text(q, "\\Q");
                m = $urandom_range(4);
                repeat (m) append_byte(q, pick_byte("()[]a\\"));
                push_text(q, "\\E");
            end
            else
                append_byte(q, 8'($urandom));
        end
        // Most patterns close what they opened; the rest leave groups open
        // to be dropped at the end.
        if ($urandom_range(99) < 75)
            repeat (open_groups) append_byte(q, CH_RPAREN);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Plain and named groups, the non-capturing forms, a group report that
    // coincides with the end of the pattern, unmatched ')' and groups left
    // open at the end; also the zero byte and the all-ones byte.
    task automatic test_basic_groups();
        send_text("(a)");
        send_text("(?')(?<_)(?P<)(*)");
        send_text("x(?:b))(?P)(?");
        send_byte(CH_LPAREN, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_RPAREN, 1'b1);
        drain_results();
    endtask

    // Escaped parentheses, quoted literal runs ending in \E after a doubled
    // backslash, and a \Q opened inside a class that only takes hold once
    // the class has closed.
    task automatic test_mode_tracking();
        send_text("\\(\\Q()\\\\E(x)");
        send_text("[\\Q](\\E)]((x)");
        send_text("[(]\\Q\\x\\E()");
        drain_results();
    endtask

    // One '(' more than the stack holds raises the sticky flag; every group
    // still closes, two ')' are left unmatched, and the next pattern starts
    // with the flag clear.
    task automatic test_nesting_limit();
        text_t q;
        repeat (MAX_NESTING + 1) append_byte(q, CH_LPAREN);
        repeat (MAX_NESTING + 2) append_byte(q, CH_RPAREN);
        append_byte(q, CH_LOWER_A);
        send_pattern(q);
        send_text("()");
        drain_results();
    endtask

    task automatic test_random_patterns();
        text_t q;
        int    start_bytes;
        start_bytes = bytes_offered;
        while (bytes_offered - start_bytes < RANDOM_BYTES)
        begin
            build_pattern(q);
            send_pattern(q);
        end
        drain_results();
    endtask

    // The same traffic with no idling on either side.
    task automatic test_back_to_back();
        text_t q;
        int    start_bytes;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        start_bytes = bytes_offered;
        while (bytes_offered - start_bytes < BURST_BYTES)
        begin
            build_pattern(q);
            send_pattern(q);
        end
        drain_results();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    // The receiver holds off while the sender keeps offering a pattern full
    // of groups, so a result waits in the core and the input stalls.
    task automatic test_output_hold_off();
        text_t q;
        int    i;
        hold_request = 1'b1;
        for (i = 0; i < 40; i++)
            push_text(q, "()");
        send_pattern(q);
        build_pattern(q);
        send_pattern(q);
        drain_results();
    endtask

    // One pattern longer than the limit. Groups open and close all along it
    // so that start positions reach high values, a group closes on the last
    // counted byte, and the bytes past the limit are dropped while the flag
    // is raised. Filler holds no backslash or '[' so the last group is seen.
    task automatic test_length_limit();
        text_t q;
        int    p;
        int    depth;
        int    kind;
        depth = 0;
        for (p = 0; p < MAX_PATTERN_LEN; p++)
        begin
            kind = $urandom_range(99);
            if ((p == 0) || (p == MAX_PATTERN_LEN - 2))
            begin
                append_byte(q, CH_LPAREN);
                depth++;
            end
            else if (p == MAX_PATTERN_LEN - 1)
                append_byte(q, CH_RPAREN);
            else if ((kind < 15) && (depth < 6))
            begin
                append_byte(q, CH_LPAREN);
                depth++;
            end
            else if (kind < 30)
            begin
                append_byte(q, CH_RPAREN);
                if (depth > 0)
                    depth--;
            end
            else if (kind < 40)
                append_byte(q, pick_byte("?*<'P_"));
            else
                append_byte(q, CH_LOWER_A + 8'($urandom_range(25)));
        end
        push_text(q, "()()x");
        send_pattern(q);
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n               <= 1'b0;
        pat_if.valid        <= 1'b0;
        pat_if.pattern_byte <= 8'h00;
        pat_if.is_final     <= 1'b0;
        clear_scan_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_groups();
        test_mode_tracking();
        test_nesting_limit();
        test_random_patterns();
        test_back_to_back();
        test_output_hold_off();
        test_length_limit();

        $display("Scanned %0d patterns in %0d bytes: %0d group spans, %0d pattern ends checked.",
                 patterns_sent, bytes_taken, groups_reported, done_reported);
        $display("Input stalled %0d cycles, %0d long receiver hold-offs, %0d results flagged overflow.",
                 stall_cycles, hold_count, ovf_reported);
        if (error_count == 0)
            $display("regex_capture_group_scanner_core: match");
        else
            $display("regex_capture_group_scanner_core: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rcgs_pkg.sv
hw/rtl/rcgs_in_if.sv
hw/rtl/rcgs_out_if.sv
hw/rtl/rcgs_mode_ctrl.sv
hw/rtl/rcgs_group_stack.sv
hw/rtl/regex_capture_group_scanner_core.sv
tb/sv/regex_capture_group_scanner_core_tb.sv
